// File: sv/ncwh_pkg.sv
// ----------------------------------------------------------------------------
// ncwh_pkg
// Shared types and constants of the nearest codeword histogram block.
// ----------------------------------------------------------------------------
package ncwh_pkg;

  // Default configuration of the block
  localparam int unsigned DIM_DEF        = 128;
  localparam int unsigned WORDS_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned WORD_IDX_W = 6;
  localparam int unsigned ELEM_IDX_W = 7;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned DIST_W     = 40;
  localparam int unsigned BIN_W      = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Result kinds
  localparam logic KIND_NEAREST = 1'b0;
  localparam logic KIND_BIN     = 1'b1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_DESC  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  // Input word
  typedef struct packed {
    req_e                  req_type;
    logic [WORD_IDX_W-1:0] word_index;
    logic [ELEM_IDX_W-1:0] element_index;
    logic [VALUE_W-1:0]    value;
    logic                  last_element;
  } req_t;

  // Result word
  typedef struct packed {
    logic                  result_kind;
    logic [WORD_IDX_W-1:0] nearest_index;
    logic                  no_match;
    logic [DIST_W-1:0]     best_distance;
    logic [BIN_W-1:0]      bin_count;
  } res_t;

  // Control travelling with a word read into the distance pipeline
  typedef struct packed {
    logic valid;
    logic add_en;
    logic zero_acc;
  } dist_ctl_t;

  // Status and result leaving the distance pipeline
  typedef struct packed {
    logic              valid;
    logic              busy;
    logic [DIST_W-1:0] acc;
  } dist_out_t;

endpackage

// File: sv/nearest_codeword_histogram.sv
// ----------------------------------------------------------------------------
// nearest_codeword_histogram
// Vector quantiser with a bag-of-words histogram over WORDS codewords.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  request   start, busy, req_i          taken when start high and busy low
//  result    res_valid_o, res_o          one-cycle strobe, never held off
//  config    cfg_we_i, cfg_wdata_i       written on any edge with cfg_we_i
//
//  A codebook load leaves busy low. A descriptor element with an in-range
//  index, or the last element, sweeps all codewords through the shared
//  difference-square pipeline and keeps busy high until it has drained;
//  the last element then reads and updates the winning bin, and its result
//  strobes in the first cycle with busy low. A bin read keeps busy high
//  through its read and response states and strobes its result likewise; a
//  histogram clear, and the clearing pass after reset, keep busy high until
//  every bin is zeroed. Results are strobed once and are not stalled.
// ----------------------------------------------------------------------------
module nearest_codeword_histogram #(
  parameter int unsigned DIM        = ncwh_pkg::DIM_DEF,
  parameter int unsigned WORDS      = ncwh_pkg::WORDS_DEF,
  parameter int unsigned VALUE_BITS = ncwh_pkg::VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = ncwh_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ncwh_pkg::req_t              req_i,
  output logic                        res_valid_o,
  output ncwh_pkg::res_t              res_o,
  input  logic                        cfg_we_i,
  input  logic [ncwh_pkg::DIST_W-1:0] cfg_wdata_i
);

  import ncwh_pkg::*;

  localparam int unsigned WIDX     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CB_DEPTH = WORDS * DIM;
  localparam int unsigned CBA      = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
  localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORDS - 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SWEEP, ST_DRAIN, ST_HREAD,
    ST_HUPD, ST_BREAD, ST_BRESP, ST_CLEAR
  } state_e;

  state_e                state_q;
  logic [WIDX-1:0]       cnt_q;
  logic [DIST_W-1:0]     reject_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [ELEM_IDX_W-1:0] elem_q;
  logic                  elem_ok_q;
  logic                  last_q;
  logic [WORD_IDX_W-1:0] word_q;
  logic                  word_ok_q;
  logic                  acc_zero_q;
  logic [DIST_W-1:0]     best_q;
  logic [WIDX-1:0]       best_w_q;
  dist_ctl_t             rd_ctl_q;
  logic [WIDX-1:0]       rd_w_q;
  res_t                  res_q;

  logic                  accept;
  logic                  in_word_ok;
  logic                  in_elem_ok;
  logic                  cb_we;
  logic [CBA-1:0]        cb_wr_addr;
  logic [CBA-1:0]        cb_rd_addr;
  logic [VALUE_BITS-1:0] cb_rdata;
  logic                  acc_we;
  logic                  bin_we;
  logic [WIDX-1:0]       bin_addr;
  logic [COUNT_BITS-1:0] bin_wdata;
  logic [WIDX-1:0]       wr_addr;
  logic [WIDX-1:0]       rd_addr;
  logic [DIST_W-1:0]     acc_rdata;
  logic [COUNT_BITS-1:0] bin_rdata;
  logic                  match;
  dist_out_t             pipe_out;
  logic [WIDX-1:0]       pipe_word;

  // Request decode
  assign accept     = start && (state_q == ST_IDLE);
  assign busy       = (state_q != ST_IDLE);
  assign in_word_ok = (32'(req_i.word_index) < WORDS);
  assign in_elem_ok = (32'(req_i.element_index) < DIM);
  assign match      = (best_q < reject_q);

  // Codebook addressing: loads straight from the request, sweeps by codeword
  assign cb_we      = accept && (req_i.req_type == REQ_LOAD) && in_word_ok && in_elem_ok;
  assign cb_wr_addr = CBA'(32'(req_i.word_index) * DIM + 32'(req_i.element_index));
  assign cb_rd_addr = CBA'(32'(cnt_q) * DIM + (elem_ok_q ? 32'(elem_q) : 32'd0));

  // Per-codeword store port selection
  always_comb begin
    unique case (state_q)
      ST_HREAD: rd_addr = best_w_q;
      ST_BREAD: rd_addr = WIDX'(word_q);
      default:  rd_addr = cnt_q;
    endcase
  end

  always_comb begin
    bin_we    = 1'b0;
    bin_addr  = cnt_q;
    bin_wdata = '0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        bin_we = 1'b1;
      end
      ST_HUPD: begin
        bin_we    = match && !(&bin_rdata);
        bin_addr  = best_w_q;
        bin_wdata = bin_rdata + 1'b1;
      end
      default: begin
        bin_we = 1'b0;
      end
    endcase
  end

  assign acc_we  = pipe_out.valid;
  assign wr_addr = acc_we ? pipe_word : bin_addr;

  ncwh_cb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CB_DEPTH)
  ) u_cb_ram (
    .clk_i     (clk_i),
    .we_i      (cb_we),
    .wr_addr_i (cb_wr_addr),
    .wr_data_i (VALUE_BITS'(req_i.value)),
    .rd_addr_i (cb_rd_addr),
    .rd_data_o (cb_rdata)
  );

  ncwh_word_ram #(
    .WORDS      (WORDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_word_ram (
    .clk_i       (clk_i),
    .acc_we_i    (acc_we),
    .bin_we_i    (bin_we),
    .wr_addr_i   (wr_addr),
    .acc_wdata_i (pipe_out.acc),
    .bin_wdata_i (bin_wdata),
    .rd_addr_i   (rd_addr),
    .acc_rdata_o (acc_rdata),
    .bin_rdata_o (bin_rdata)
  );

  ncwh_dist_pipe #(
    .VALUE_BITS (VALUE_BITS),
    .WIDX       (WIDX)
  ) u_dist_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rd_ctl_q),
    .word_i     (rd_w_q),
    .val_i      (val_q),
    .cb_data_i  (cb_rdata),
    .acc_data_i (acc_rdata),
    .out_o      (pipe_out),
    .word_o     (pipe_word)
  );

  // Sequencer, read control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      reject_q    <= DIST_MAX;
      acc_zero_q  <= 1'b1;
      rd_ctl_q    <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o       <= 1'b0;
      rd_ctl_q.valid    <= (state_q == ST_SWEEP);
      rd_ctl_q.add_en   <= elem_ok_q;
      rd_ctl_q.zero_acc <= acc_zero_q;
      if (cfg_we_i) begin
        reject_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_INIT, ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_WORD) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cnt_q <= '0;
            unique case (req_i.req_type)
              REQ_LOAD: begin
                state_q <= ST_IDLE;
              end
              REQ_DESC: begin
                if (req_i.element_index == '0) begin
                  acc_zero_q <= 1'b1;
                end
                if (in_elem_ok || req_i.last_element) begin
                  state_q <= ST_SWEEP;
                end
              end
              REQ_READ: begin
                state_q <= ST_BREAD;
              end
              REQ_CLEAR: begin
                state_q <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_WORD) begin
            cnt_q      <= '0;
            acc_zero_q <= 1'b0;
            state_q    <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_ctl_q.valid && !pipe_out.busy) begin
            state_q <= last_q ? ST_HREAD : ST_IDLE;
          end
        end
        ST_HREAD: begin
          state_q <= ST_HUPD;
        end
        ST_HUPD: begin
          res_valid_o <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_BREAD: begin
          state_q <= ST_BRESP;
        end
        ST_BRESP: begin
          res_valid_o <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch the request, track the minimum, build the result word
  always_ff @(posedge clk_i) begin
    rd_w_q <= cnt_q;
    if (accept) begin
      val_q     <= VALUE_BITS'(req_i.value);
      elem_q    <= req_i.element_index;
      elem_ok_q <= in_elem_ok;
      word_q    <= req_i.word_index;
      word_ok_q <= in_word_ok;
    end
    if (pipe_out.valid && ((pipe_word == '0) || (pipe_out.acc < best_q))) begin
      best_q   <= pipe_out.acc;
      best_w_q <= pipe_word;
    end
    if (state_q == ST_HUPD) begin
      res_q.result_kind   <= KIND_NEAREST;
      res_q.nearest_index <= WORD_IDX_W'(best_w_q);
      res_q.no_match      <= !match;
      res_q.best_distance <= best_q;
      res_q.bin_count     <= '0;
    end else if (state_q == ST_BRESP) begin
      res_q.result_kind   <= KIND_BIN;
      res_q.nearest_index <= word_q;
      res_q.no_match      <= 1'b0;
      res_q.best_distance <= '0;
      res_q.bin_count     <= word_ok_q ? BIN_W'(bin_rdata) : '0;
    end
  end

  // Hold last_q with the request; it is control, so it resets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (accept) begin
      last_q <= req_i.last_element;
    end
  end

  assign res_o = res_q;

  // Accumulator write-back only while a sweep is in flight
  a_acc_wb_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_out.valid |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
    else $error("accumulator write outside a sweep");

  // The two fields never compete for the write port
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_we && bin_we))
    else $error("accumulator and bin written in one cycle");

  // Idle means the pipeline is empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (!rd_ctl_q.valid && !pipe_out.busy))
    else $error("pipeline busy while idle");

  // A result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

// File: sv/ncwh_cb_ram.sv
// ----------------------------------------------------------------------------
// ncwh_cb_ram
// Codebook store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ncwh_cb_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 8192,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// File: sv/ncwh_word_ram.sv
// ----------------------------------------------------------------------------
// ncwh_word_ram
// Per-codeword store: distance accumulator and histogram bin, written as
// separate fields at one address, read together with registered data.
// ----------------------------------------------------------------------------
module ncwh_word_ram #(
  parameter  int unsigned WORDS      = 64,
  parameter  int unsigned COUNT_BITS = 16,
  localparam int unsigned WIDX       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                      clk_i,
  input  logic                      acc_we_i,
  input  logic                      bin_we_i,
  input  logic [WIDX-1:0]           wr_addr_i,
  input  logic [ncwh_pkg::DIST_W-1:0] acc_wdata_i,
  input  logic [COUNT_BITS-1:0]     bin_wdata_i,
  input  logic [WIDX-1:0]           rd_addr_i,
  output logic [ncwh_pkg::DIST_W-1:0] acc_rdata_o,
  output logic [COUNT_BITS-1:0]     bin_rdata_o
);

  import ncwh_pkg::*;

  logic [DIST_W-1:0]     acc_mem [WORDS];
  logic [COUNT_BITS-1:0] bin_mem [WORDS];

  // Field writes
  always_ff @(posedge clk_i) begin
    if (acc_we_i) begin
      acc_mem[wr_addr_i] <= acc_wdata_i;
    end
    if (bin_we_i) begin
      bin_mem[wr_addr_i] <= bin_wdata_i;
    end
  end

  // Registered read of the whole entry
  always_ff @(posedge clk_i) begin
    acc_rdata_o <= acc_mem[rd_addr_i];
    bin_rdata_o <= bin_mem[rd_addr_i];
  end

endmodule

// File: sv/ncwh_dist_pipe.sv
// ----------------------------------------------------------------------------
// ncwh_dist_pipe
// Shared difference-square unit: squares the element difference for one
// codeword per cycle and, when adding is enabled, adds it to that codeword's accumulator, saturating.
// ----------------------------------------------------------------------------
module ncwh_dist_pipe #(
  parameter  int unsigned VALUE_BITS = 16,
  parameter  int unsigned WIDX       = 6,
  localparam int unsigned SQW        = 2 * VALUE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ncwh_pkg::dist_ctl_t         ctl_i,
  input  logic [WIDX-1:0]             word_i,
  input  logic [VALUE_BITS-1:0]       val_i,
  input  logic [VALUE_BITS-1:0]       cb_data_i,
  input  logic [ncwh_pkg::DIST_W-1:0] acc_data_i,
  output ncwh_pkg::dist_out_t         out_o,
  output logic [WIDX-1:0]             word_o
);

  import ncwh_pkg::*;

  localparam int unsigned SUMW = ((SQW > DIST_W) ? SQW : DIST_W) + 1;

  logic [VALUE_BITS-1:0] diff;
  logic [SQW-1:0]        sq;
  logic [SUMW-1:0]       sum;

  logic                  s1_v_q;
  logic                  s1_add_q;
  logic [WIDX-1:0]       s1_w_q;
  logic [SQW-1:0]        s1_sq_q;
  logic [DIST_W-1:0]     s1_acc_q;

  logic                  out_v_q;
  logic [WIDX-1:0]       out_w_q;
  logic [DIST_W-1:0]     out_acc_q;

  // Absolute difference and its square
  always_comb begin
    diff = (val_i >= cb_data_i) ? (val_i - cb_data_i) : (cb_data_i - val_i);
    sq   = SQW'(diff) * SQW'(diff);
  end

  // Saturating accumulate
  assign sum = SUMW'(s1_acc_q) + (s1_add_q ? SUMW'(s1_sq_q) : SUMW'(0));

  // Control of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= ctl_i.valid;
      out_v_q <= s1_v_q;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    s1_add_q  <= ctl_i.add_en;
    s1_w_q    <= word_i;
    s1_sq_q   <= sq;
    s1_acc_q  <= ctl_i.zero_acc ? '0 : acc_data_i;
    out_w_q   <= s1_w_q;
    out_acc_q <= (sum >= SUMW'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  end

  assign out_o.valid = out_v_q;
  assign out_o.busy  = s1_v_q | out_v_q;
  assign out_o.acc   = out_acc_q;
  assign word_o      = out_w_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest codeword histogram block. A shadow
// copy of the codebook, the distance sums, the histogram and the reject
// threshold predicts every result word. Directed tests cover ties, the
// reject threshold, extreme values, clearing and distance saturation.
// Random traffic follows: mostly well-formed descriptors near a chosen
// codeword, with loads, bin reads, clears and broken descriptors mixed in.
// ----------------------------------------------------------------------------
module tb_top;
  import ncwh_pkg::*;

  localparam int unsigned DIM           = DIM_DEF;
  localparam int unsigned WORDS         = WORDS_DEF;
  localparam int unsigned SAT_STEPS     = 260;
  localparam int unsigned SETTLE_CYCLES = 2 * WORDS + 16;
  localparam int unsigned DRAIN_CYCLES  = 4000;
  localparam int unsigned RAND_PHASES   = 5;
  localparam int unsigned PHASE_ITEMS   = 80;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [BIN_W-1:0] BIN_FULL = {BIN_W{1'b1}};

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  req_t              req;
  logic              res_valid;
  res_t              res;
  logic              cfg_we;
  logic [DIST_W-1:0] cfg_wdata;

  // Shadow state of the block
  logic [VALUE_W-1:0] cb_val [WORDS][DIM];
  bit                 cb_set [WORDS][DIM];
  int unsigned        col_fill [DIM];
  int unsigned        ready_cols [$];
  logic [DIST_W-1:0]  dist_sum [WORDS];
  logic [BIN_W-1:0]   hist_cnt [WORDS];
  logic [DIST_W-1:0]  reject_thr;

  res_t              pending_res_q [$];
  int unsigned       fault_cnt;
  int unsigned       items_sent;
  int unsigned       idle_pct;
  longint unsigned   cycle_cnt;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  nearest_codeword_histogram i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Build one request word
  function automatic req_t make_req(input req_e kind, input int unsigned w,
                                    input int unsigned e, input int unsigned v,
                                    input bit fin);
    req_t r;
    r.req_type      = kind;
    r.word_index    = w[WORD_IDX_W-1:0];
    r.element_index = e[ELEM_IDX_W-1:0];
    r.value         = v[VALUE_W-1:0];
    r.last_element  = fin;
    return r;
  endfunction

  // Element value with the extremes weighted up
  function automatic int unsigned rand_value();
    int unsigned pick;
    pick = $urandom_range(7, 0);
    if (pick == 0) return 0;
    if (pick == 1) return 16'hFFFF;
    return $urandom_range(16'hFFFF, 0);
  endfunction

  // Advance the shadow state by one accepted word and queue any result it gives
  function automatic void quantise_word(input req_t r);
    longint unsigned v, c, diff, sq, acc, sat;
    logic [DIST_W-1:0] best;
    int unsigned best_w, e;
    res_t want;
    want = '0;
    e    = 32'(r.element_index);
    sat  = 64'(DIST_MAX);
    case (r.req_type)
      REQ_LOAD: begin
        cb_val[r.word_index][e] = r.value;
        if (!cb_set[r.word_index][e]) begin
          cb_set[r.word_index][e] = 1'b1;
          col_fill[e]++;
          if (col_fill[e] == WORDS) ready_cols = {ready_cols, e};
        end
      end
      REQ_CLEAR: begin
        foreach (hist_cnt[w]) hist_cnt[w] = '0;
      end
      REQ_READ: begin
        want.result_kind   = KIND_BIN;
        want.nearest_index = r.word_index;
        want.bin_count     = hist_cnt[r.word_index];
        pending_res_q      = {pending_res_q, want};
      end
      REQ_DESC: begin
        // Element zero restarts every sum
        if (e == 0) foreach (dist_sum[w]) dist_sum[w] = '0;
        v = 64'(r.value);
        foreach (dist_sum[w]) begin
          c    = 64'(cb_val[w][e]);
          diff = (v >= c) ? v - c : c - v;
          sq   = diff * diff;
          acc  = 64'(dist_sum[w]);
          dist_sum[w] = (sq >= sat - acc) ? DIST_MAX : DIST_W'(acc + sq);
        end
        if (r.last_element) begin
          best   = dist_sum[0];
          best_w = 0;
          for (int w = 1; w < WORDS; w++) begin
            if (dist_sum[w] < best) begin
              best   = dist_sum[w];
              best_w = w;
            end
          end
          if (best < reject_thr) begin
            if (hist_cnt[best_w] != BIN_FULL) hist_cnt[best_w] = hist_cnt[best_w] + 1'b1;
          end else begin
            want.no_match = 1'b1;
          end
          want.result_kind   = KIND_NEAREST;
          want.nearest_index = best_w[WORD_IDX_W-1:0];
          want.best_distance = best;
          pending_res_q      = {pending_res_q, want};
        end
      end
    endcase
  endfunction

  // Offer one word, idling cycle by cycle at random, and wait for acceptance
  task automatic send_word(input req_t r);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    quantise_word(r);
    items_sent++;
  endtask

  // Wait for every pending result, with a bound
  task automatic drain_results();
    int unsigned n;
    n = 0;
    while (pending_res_q.size() != 0 && n < DRAIN_CYCLES) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Drop start and let the block run dry
  task automatic settle();
    start <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reject(input logic [DIST_W-1:0] thr);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    reject_thr = thr;
  endtask

  // Two-element descriptor equal to codeword w on columns 0 and 127
  task automatic send_copy_of(input int unsigned w);
    send_word(make_req(REQ_DESC, $urandom_range(63, 0), 0, cb_val[w][0], 1'b0));
    send_word(make_req(REQ_DESC, $urandom_range(63, 0), 127, cb_val[w][127], 1'b1));
  endtask

  task automatic send_read(input int unsigned w);
    send_word(make_req(REQ_READ, w, $urandom_range(127, 0), $urandom_range(16'hFFFF, 0),
                       1'($urandom_range(1, 0))));
  endtask

  // Descriptor run: whole ones start at element zero and end with last
  task automatic send_descriptor_run(input bit whole);
    int unsigned len, tgt, e;
    int          sv;
    bit          near, closes;
    len    = $urandom_range(6, 1);
    tgt    = $urandom_range(WORDS - 1, 0);
    near   = $urandom_range(3, 0) != 0;
    closes = whole || $urandom_range(1, 0);
    for (int j = 0; j < len; j++) begin
      e = (whole && j == 0) ? 0 : ready_cols[$urandom_range(ready_cols.size() - 1, 0)];
      if (near) begin
        sv = int'(cb_val[tgt][e]);
        if ($urandom_range(2, 0) != 0) sv = sv + int'($urandom_range(256, 0)) - 128;
        if (sv < 0) sv = 0;
        if (sv > 16'hFFFF) sv = 16'hFFFF;
      end else begin
        sv = rand_value();
      end
      send_word(make_req(REQ_DESC, $urandom_range(63, 0), e, sv,
                         closes && (j == len - 1)));
    end
  endtask

  // Complete the codebook on one column that is not yet fully loaded
  task automatic fill_free_column();
    int unsigned e;
    do e = $urandom_range(DIM - 1, 0); while (col_fill[e] == WORDS);
    for (int w = 0; w < WORDS; w++) begin
      if (!cb_set[w][e])
        send_word(make_req(REQ_LOAD, w, e, rand_value(), 1'($urandom_range(1, 0))));
    end
  endtask

  task automatic test_bins_after_reset();
    send_read(0);
    send_read(WORDS - 1);
  endtask

  // Columns 0, 1 and 127 for every codeword; codeword 12 copies 7,
  // codeword 3 sits at full scale and column 1 is all zero
  task automatic load_codebook_columns();
    int unsigned cols [3];
    int unsigned v;
    cols = '{0, 1, 127};
    foreach (cols[k]) begin
      for (int w = 0; w < WORDS; w++) begin
        if (cols[k] == 1)  v = 0;
        else if (w == 3)   v = 16'hFFFF;
        else if (w == 12)  v = cb_val[7][cols[k]];
        else               v = $urandom_range(16'hFFFF, 0);
        send_word(make_req(REQ_LOAD, w, cols[k], v, 1'($urandom_range(1, 0))));
      end
    end
  endtask

  // Equal codewords: lowest index must win
  task automatic test_nearest_tie();
    send_copy_of(12);
    send_read(7);
    send_read(12);
  endtask

  // Zero distance is not below a zero threshold but is below one
  task automatic test_reject_threshold();
    write_reject('0);
    send_copy_of(7);
    send_read(7);
    write_reject(40'd1);
    send_copy_of(7);
    send_read(7);
    write_reject(DIST_MAX);
  endtask

  // Full-scale and zero values, single-element and unrestarted descriptors
  task automatic test_extreme_values();
    send_word(make_req(REQ_DESC, 0, 0, 16'hFFFF, 1'b0));
    send_word(make_req(REQ_DESC, 63, 127, 16'hFFFF, 1'b1));
    send_word(make_req(REQ_DESC, 63, 0, 0, 1'b1));
    send_word(make_req(REQ_DESC, 0, 127, 16'hFFFF, 1'b1));
    send_read(3);
  endtask

  task automatic test_clear_histogram();
    send_word(make_req(REQ_CLEAR, 63, 127, 16'hFFFF, 1'b1));
    send_read(3);
    send_read(7);
    send_copy_of(12);
    send_read(7);
  endtask

  // Pile full-scale differences on the zero column until every sum saturates
  task automatic test_distance_saturation();
    idle_pct = 0;
    send_word(make_req(REQ_DESC, 0, 0, $urandom_range(16'hFFFF, 0), 1'b0));
    for (int i = 0; i < SAT_STEPS; i++)
      send_word(make_req(REQ_DESC, 0, 1, 16'hFFFF, i == SAT_STEPS - 1));
    idle_pct = 24;
  endtask

  task automatic test_random_traffic();
    int unsigned       phase_start, pick;
    logic [DIST_W-1:0] thr;
    for (int p = 0; p < RAND_PHASES; p++) begin
      // Log-spread threshold, full scale in the phase without idling
      thr = DIST_W'(({$urandom, $urandom} & 64'(DIST_MAX)) >> $urandom_range(DIST_W - 1, 0));
      idle_pct = (p == 2) ? 0 : 24;
      write_reject((p == 2) ? DIST_MAX : thr);
      if (p == 1 || p == 3) fill_free_column();
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        if (pick < 60)
          send_descriptor_run(1'b1);
        else if (pick < 70)
          send_descriptor_run(1'b0);
        else if (pick < 82)
          send_word(make_req(REQ_LOAD, $urandom_range(63, 0), $urandom_range(127, 0),
                             rand_value(), 1'($urandom_range(1, 0))));
        else if (pick < 97)
          send_read($urandom_range(WORDS - 1, 0));
        else
          send_word(make_req(REQ_CLEAR, $urandom_range(63, 0), $urandom_range(127, 0),
                             $urandom_range(16'hFFFF, 0), 1'($urandom_range(1, 0))));
      end
    end
    idle_pct = 24;
  endtask

  function automatic void note_fault(input string what, input res_t want, input res_t got);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS)
      $display("%0t %s: exp kind %0d idx %0d nm %0d dist %h bin %0d / got kind %0d idx %0d nm %0d dist %h bin %0d",
               $time, what, want.result_kind, want.nearest_index, want.no_match,
               want.best_distance, want.bin_count, got.result_kind, got.nearest_index,
               got.no_match, got.best_distance, got.bin_count);
  endfunction

  // Compare each strobed result word with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && res_valid) begin
      if (pending_res_q.size() == 0) begin
        note_fault("unexpected result", '0, res);
      end else begin
        want = pending_res_q.pop_front();
        if (res.result_kind !== want.result_kind || res.nearest_index !== want.nearest_index ||
            res.no_match !== want.no_match || res.best_distance !== want.best_distance ||
            res.bin_count !== want.bin_count)
          note_fault("mismatch", want, res);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    start      <= 1'b0;
    req        <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    cycle_cnt  = 0;
    fault_cnt  = 0;
    items_sent = 0;
    idle_pct   = 24;
    reject_thr = DIST_MAX;
    foreach (dist_sum[w]) dist_sum[w] = '0;
    foreach (hist_cnt[w]) hist_cnt[w] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_bins_after_reset();
    load_codebook_columns();
    test_nearest_tie();
    test_reject_threshold();
    test_extreme_values();
    test_clear_histogram();
    test_distance_saturation();
    test_random_traffic();

    settle();
    if (pending_res_q.size() != 0) begin
      if (fault_cnt < MAX_REPORTS)
        $display("%0d expected results never arrived", pending_res_q.size());
      fault_cnt += pending_res_q.size();
    end
    if (fault_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
